// ===== hw/rtl/tlpq_pkg.sv =====
// Shared types and codes for the two-level priority queue.
// Holds item payload structs, operation codes and controller types.
// No dependencies.
package tlpq_pkg;

  // Width of one request id
  localparam int unsigned IdW = 16;

  // Operation codes carried in the mode field; the fourth code is unused
  typedef enum logic [1:0] {
    MODE_SUBMIT = 2'd0,
    MODE_SERVE  = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_e;

  // Input item
  typedef struct packed {
    logic [1:0]     mode;
    logic [IdW-1:0] request_id;
    logic           high_priority;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic           accepted;
    logic           found;
    logic [IdW-1:0] out_id;
    logic           out_high;
  } rsp_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // access the rings and update pointers
  } dp_cmd_t;

endpackage

// ===== hw/rtl/tlpq_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on tlpq_pkg for the payload structs.
interface tlpq_req_if;
  import tlpq_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tlpq_rsp_if;
  import tlpq_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/tlpq_ctrl.sv =====
// Controller state machine: sequences capture, ring access and result hold.
// Depends on tlpq_pkg for states and the command struct.
module tlpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlpq_pkg::dp_cmd_t cmd_o
);
  import tlpq_pkg::*;

  ctrl_state_e state_q, state_d;

  // Advance through capture, access and result phases
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive handshakes and datapath commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/tlpq_dp.sv =====
// Datapath: two ring buffers with head pointers and counts, result register.
// Depends on tlpq_pkg for item structs, mode codes and the command struct.
module tlpq_dp #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlpq_pkg::dp_cmd_t   cmd_i,
  input  tlpq_pkg::req_item_t req_i,
  output tlpq_pkg::rsp_item_t rsp_o
);
  import tlpq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [CntW:0]   DepthSum = (CntW + 1)'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);

  logic [IdW-1:0] high_mem [QUEUE_DEPTH];
  logic [IdW-1:0] low_mem  [QUEUE_DEPTH];

  logic [1:0]      mode_q;
  logic [IdW-1:0]  id_q;
  logic            hp_q;
  logic [IdxW-1:0] high_head_q, high_head_d, low_head_q, low_head_d;
  logic [CntW-1:0] high_cnt_q, high_cnt_d, low_cnt_q, low_cnt_d;
  logic            acc_q, found_q, out_high_q;
  logic [IdW-1:0]  high_rd_q, low_rd_q;

  logic            is_submit, is_serve, is_lookup;
  logic            high_we, low_we, take_high, take_low;
  logic [IdxW-1:0] high_tail, low_tail;
  logic [CntW:0]   high_sum, low_sum;

  // Decode the captured operation
  assign is_submit = (mode_q == MODE_SUBMIT);
  assign is_serve  = (mode_q == MODE_SERVE);
  assign is_lookup = (mode_q == MODE_SERVE) || (mode_q == MODE_PEEK);

  // Locate the tail of each ring: head plus count, wrapped once
  assign high_sum  = (CntW + 1)'(high_head_q) + (CntW + 1)'(high_cnt_q);
  assign low_sum   = (CntW + 1)'(low_head_q) + (CntW + 1)'(low_cnt_q);
  assign high_tail = (high_sum >= DepthSum) ? IdxW'(high_sum - DepthSum) : IdxW'(high_sum);
  assign low_tail  = (low_sum >= DepthSum) ? IdxW'(low_sum - DepthSum) : IdxW'(low_sum);

  // Store only when the selected ring has room
  assign high_we = cmd_i.exec && is_submit && hp_q && (high_cnt_q != DepthCnt);
  assign low_we  = cmd_i.exec && is_submit && !hp_q && (low_cnt_q != DepthCnt);

  // Pick the high ring first, then the low ring
  assign take_high = is_lookup && (high_cnt_q != '0);
  assign take_low  = is_lookup && (high_cnt_q == '0) && (low_cnt_q != '0);

  // Update pointers and counts
  always_comb begin
    high_head_d = high_head_q;
    high_cnt_d  = high_cnt_q;
    low_head_d  = low_head_q;
    low_cnt_d   = low_cnt_q;
    if (cmd_i.exec) begin
      if (high_we) high_cnt_d = high_cnt_q + CntW'(1);
      if (low_we)  low_cnt_d  = low_cnt_q + CntW'(1);
      if (is_serve && take_high) begin
        high_head_d = (high_head_q == LastIdx) ? '0 : high_head_q + IdxW'(1);
        high_cnt_d  = high_cnt_q - CntW'(1);
      end
      if (is_serve && take_low) begin
        low_head_d = (low_head_q == LastIdx) ? '0 : low_head_q + IdxW'(1);
        low_cnt_d  = low_cnt_q - CntW'(1);
      end
    end
  end

  // Write rings on submit and register the head entries on lookup
  always_ff @(posedge clk_i) begin
    if (high_we) high_mem[high_tail] <= id_q;
    if (low_we)  low_mem[low_tail]   <= id_q;
    if (cmd_i.exec && is_lookup) begin
      high_rd_q <= high_mem[high_head_q];
      low_rd_q  <= low_mem[low_head_q];
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= req_i.mode;
      id_q   <= req_i.request_id;
      hp_q   <= req_i.high_priority;
    end
  end

  // Hold ring state and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_head_q <= '0;
      high_cnt_q  <= '0;
      low_head_q  <= '0;
      low_cnt_q   <= '0;
      acc_q       <= 1'b0;
      found_q     <= 1'b0;
      out_high_q  <= 1'b0;
    end else begin
      high_head_q <= high_head_d;
      high_cnt_q  <= high_cnt_d;
      low_head_q  <= low_head_d;
      low_cnt_q   <= low_cnt_d;
      if (cmd_i.exec) begin
        acc_q      <= high_we || low_we;
        found_q    <= take_high || take_low;
        out_high_q <= take_high;
      end
    end
  end

  // Form the result item; the id reads as zero when nothing was found
  always_comb begin
    rsp_o.accepted = acc_q;
    rsp_o.found    = found_q;
    rsp_o.out_high = out_high_q;
    if (!found_q) begin
      rsp_o.out_id = '0;
    end else if (out_high_q) begin
      rsp_o.out_id = high_rd_q;
    end else begin
      rsp_o.out_id = low_rd_q;
    end
  end

endmodule

// ===== hw/rtl/two_level_priority_queue_unit.sv =====
// Two-level strict-priority request queue. Submit appends a 16-bit id to the
// high or low ring (rejected when that ring is full); serve removes and peek
// returns the oldest high-priority id, else the oldest low-priority id, with
// found cleared when both rings are empty. Items are handled one at a time:
// each passes through capture, ring access with registered read and result,
// and the result is held until the sink takes it. Ring contents are not
// cleared at reset; only written entries ever reach the result.
// Depends on tlpq_pkg, tlpq_if, tlpq_ctrl and tlpq_dp.
module two_level_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input logic         clk_i,
  input logic         rst_ni,
  tlpq_req_if.sink    req_i,
  tlpq_rsp_if.source  rsp_o
);
  import tlpq_pkg::*;

  dp_cmd_t   cmd;
  rsp_item_t rsp_item;

  // Sequence each item
  tlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Rings, pointers and result register
  tlpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i.item),
    .rsp_o  (rsp_item)
  );

  assign rsp_o.item = rsp_item;

endmodule

// ===== verif/two_level_priority_queue_unit_tb.sv =====
// Self-checking testbench for the two-level priority queue unit.
// Drives request items, predicts each result from a queue-based model and checks it.
// Depends on tlpq_pkg, tlpq_if and two_level_priority_queue_unit.
module two_level_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int unsigned RING_DEPTH  = 128;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  // Mode code that the block must ignore
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  tlpq_req_if req_if ();
  tlpq_rsp_if rsp_if ();

  two_level_priority_queue_unit #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Request items waiting to be driven, and results owed by the block
  req_item_t   pending_req_q[$];
  rsp_item_t   expected_rsp_q[$];

  // Shadow contents of the two rings, oldest id first
  logic [IdW-1:0] high_ring_q[$];
  logic [IdW-1:0] low_ring_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned submit_count;
  int unsigned refused_count;
  int unsigned serve_count;
  int unsigned peek_count;
  int unsigned empty_lookup_count;
  int unsigned unused_count;

  rsp_item_t want_rsp;
  rsp_item_t got_rsp;

  // Work out the result of one accepted item and update the shadow rings
  function automatic rsp_item_t arbitrate_request(req_item_t req);
    rsp_item_t rsp;
    rsp = '0;
    case (req.mode)
      MODE_SUBMIT: begin
        submit_count++;
        if (req.high_priority) begin
          if (high_ring_q.size() < RING_DEPTH) begin
            high_ring_q.push_back(req.request_id);
            rsp.accepted = 1'b1;
          end
        end else begin
          if (low_ring_q.size() < RING_DEPTH) begin
            low_ring_q.push_back(req.request_id);
            rsp.accepted = 1'b1;
          end
        end
        if (!rsp.accepted) refused_count++;
      end
      MODE_SERVE, MODE_PEEK: begin
        if (req.mode == MODE_SERVE) serve_count++;
        else peek_count++;
        if (high_ring_q.size() != 0) begin
          rsp.found    = 1'b1;
          rsp.out_high = 1'b1;
          rsp.out_id   = high_ring_q[0];
          if (req.mode == MODE_SERVE) void'(high_ring_q.pop_front());
        end else if (low_ring_q.size() != 0) begin
          rsp.found  = 1'b1;
          rsp.out_id = low_ring_q[0];
          if (req.mode == MODE_SERVE) void'(low_ring_q.pop_front());
        end else begin
          empty_lookup_count++;
        end
      end
      default: begin
        unused_count++;
      end
    endcase
    return rsp;
  endfunction

  function automatic req_item_t make_req(logic [1:0] mode, logic [IdW-1:0] id, logic hp);
    req_item_t req;
    req.mode          = mode;
    req.request_id    = id;
    req.high_priority = hp;
    return req;
  endfunction

  // Queue a random mix; whatever is left after the three weights is the unused code
  task automatic queue_mixed(int unsigned n, int unsigned sub_pct, int unsigned serve_pct,
                             int unsigned peek_pct);
    int unsigned roll;
    logic [1:0]  mode;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < sub_pct) mode = MODE_SUBMIT;
      else if (roll < sub_pct + serve_pct) mode = MODE_SERVE;
      else if (roll < sub_pct + serve_pct + peek_pct) mode = MODE_PEEK;
      else mode = MODE_UNUSED;
      pending_req_q.push_back(make_req(mode, 16'($urandom), 1'($urandom_range(1))));
    end
  endtask

  // Queue a run of submits to one ring with random ids
  task automatic queue_fill(int unsigned n, logic hp);
    for (int unsigned i = 0; i < n; i++) begin
      pending_req_q.push_back(make_req(MODE_SUBMIT, 16'($urandom), hp));
    end
  endtask

  // Block until every queued item is accepted and every result has come back
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
             expected_rsp_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Driver: hold an item until accepted, predict its result at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.item  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(arbitrate_request(req_if.item));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.item  <= pending_req_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp = rsp_if.item;
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: unexpected result acc=%b found=%b id=%h high=%b", $realtime,
                     got_rsp.accepted, got_rsp.found, got_rsp.out_id, got_rsp.out_high);
          end
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (got_rsp.accepted !== want_rsp.accepted || got_rsp.found !== want_rsp.found ||
              got_rsp.out_id !== want_rsp.out_id || got_rsp.out_high !== want_rsp.out_high) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("ERROR @%0t: expected acc=%b found=%b id=%h high=%b", $realtime,
                       want_rsp.accepted, want_rsp.found, want_rsp.out_id, want_rsp.out_high);
              $display("          got      acc=%b found=%b id=%h high=%b",
                       got_rsp.accepted, got_rsp.found, got_rsp.out_id, got_rsp.out_high);
            end
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    rst_ni             = 1'b0;
    fail_count         = 0;
    submit_count       = 0;
    refused_count      = 0;
    serve_count        = 0;
    peek_count         = 0;
    empty_lookup_count = 0;
    unused_count       = 0;
    send_idle_pct      = 19;
    recv_idle_pct      = 76;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty rings, unused code, extreme ids, strict priority and ignored fields
    pending_req_q.push_back(make_req(MODE_SERVE, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_PEEK, 16'h0000, 1'b0));
    pending_req_q.push_back(make_req(MODE_UNUSED, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'h0000, 1'b0));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'hFFFF, 1'b0));
    pending_req_q.push_back(make_req(MODE_PEEK, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'h0000, 1'b1));
    pending_req_q.push_back(make_req(MODE_PEEK, 16'h1234, 1'b0));
    pending_req_q.push_back(make_req(MODE_UNUSED, 16'hA5A5, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h0000, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h5A5A, 1'b1));
    pending_req_q.push_back(make_req(MODE_PEEK, 16'h0000, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'h8001, 1'b1));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h7FFE, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h0000, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'hFFFF, 1'b0));
    pending_req_q.push_back(make_req(MODE_PEEK, 16'hFFFF, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'h5555, 1'b1));
    pending_req_q.push_back(make_req(MODE_SUBMIT, 16'hAAAA, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h0000, 1'b0));
    pending_req_q.push_back(make_req(MODE_SERVE, 16'h0000, 1'b1));

    // Phase one: slow receiver, random mix
    queue_mixed(120, 45, 25, 20);
    wait_drained();

    // Phase two: slow sender; fill the high ring past full, drain part, wrap and refill
    send_idle_pct = 76;
    recv_idle_pct = 19;
    queue_fill(132, 1'b1);
    queue_mixed(30, 0, 70, 30);
    queue_fill(10, 1'b1);
    queue_fill(20, 1'b0);
    wait_drained();

    // Phase three: full rate both sides; overflow the low ring, then drain mostly
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_fill(132, 1'b0);
    queue_mixed(170, 15, 60, 20);
    wait_drained();

    // Let any trailing activity settle
    repeat (8) @(negedge clk_i);

    $display("Ran %0d submits (%0d refused on a full ring), %0d serves, %0d peeks, %0d unused",
             submit_count, refused_count, serve_count, peek_count, unused_count);
    $display("Lookups on empty rings: %0d; mismatches: %0d", empty_lookup_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tlpq_pkg.sv
hw/rtl/tlpq_if.sv
hw/rtl/tlpq_ctrl.sv
hw/rtl/tlpq_dp.sv
hw/rtl/two_level_priority_queue_unit.sv
verif/two_level_priority_queue_unit_tb.sv
